// File: hdl/tte_pkg.sv
// Package for the three timer sound envelope block.
// Holds the queued item type, the one-hot back-end state codes and the lookup tables.
// No dependencies.
package tte_pkg;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 80;
    localparam int HZ_W       = 19;
    localparam int RATE_W     = 20;
    localparam int VOL_W      = 7;
    // The envelope step can sit one above the step count, so it needs one extra bit.
    localparam int STEP_W     = 6;
    localparam logic [HZ_W-1:0] HZ_MAX = 19'h7FFFF;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_TIMER = 2'd1;
    localparam logic [1:0] OP_BOARD = 2'd2;

    localparam logic [2:0] REG_CR13   = 3'd0;
    localparam logic [2:0] REG_CR2    = 3'd1;
    localparam logic [2:0] REG_LATCH1 = 3'd3;
    localparam logic [2:0] REG_LATCH2 = 3'd5;
    localparam logic [2:0] REG_LATCH3 = 3'd7;

    typedef struct packed {
        logic       is_tick;
        logic       is_timer_wr;
        logic       is_board_wr;
        logic       tick_internal;
        logic [2:0] reg_index;
        logic [7:0] value_high;
        logic [7:0] value_low;
    } item_t;

    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    function automatic logic [VOL_W-1:0] vol_entry(input logic [4:0] idx);
        logic [VOL_W-1:0] v;
        unique case (idx)
            5'd5:              v = 7'd10;
            5'd6, 5'd7:        v = 7'd20;
            5'd8, 5'd9:        v = 7'd30;
            5'd10, 5'd11:      v = 7'd40;
            5'd12, 5'd13:      v = 7'd60;
            5'd14:             v = 7'd80;
            5'd15:             v = 7'd90;
            5'd16, 5'd17:      v = 7'd100;
            default:           v = 7'd0;
        endcase
        return v;
    endfunction

    function automatic logic [VOL_W-1:0] vol_of(input logic [STEP_W-1:0] step,
                                                 input logic rising,
                                                 input logic [STEP_W-1:0] steps);
        logic [STEP_W-1:0] top;
        logic [STEP_W-1:0] idx;
        top = steps + STEP_W'(1);
        if (rising)
            idx = step;
        else if (step > top)
            idx = '0;
        else
            idx = top - step;
        if (idx > STEP_W'(17))
            idx = STEP_W'(17);
        if (step == '0)
            return '0;
        return vol_entry(idx[4:0]);
    endfunction

    // Noise sample rate 625000/(16-n) for the board control field n.
    function automatic logic [RATE_W-1:0] noise_rate_of(input logic [3:0] n);
        logic [RATE_W-1:0] r;
        unique case (n)
            4'd0:    r = 20'd39062;
            4'd1:    r = 20'd41666;
            4'd2:    r = 20'd44642;
            4'd3:    r = 20'd48076;
            4'd4:    r = 20'd52083;
            4'd5:    r = 20'd56818;
            4'd6:    r = 20'd62500;
            4'd7:    r = 20'd69444;
            4'd8:    r = 20'd78125;
            4'd9:    r = 20'd89285;
            4'd10:   r = 20'd104166;
            4'd11:   r = 20'd125000;
            4'd12:   r = 20'd156250;
            4'd13:   r = 20'd208333;
            4'd14:   r = 20'd312500;
            default: r = 20'd625000;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/three_timer_sound_envelope_top.sv
// Three timer sound board with volume envelope: a clock tick, a timer register write or a
// board control write goes in on each input beat and one result beat comes out for it.
// A tick or a control write is handled by the back end in its run state. A write to latch 1
// or 2 waits for the tone frequency, which comes from a restoring divider that produces one
// quotient bit per cycle. A two-entry queue in front and an output register behind let either
// side stall on its own.
// Depends on tte_pkg, tte_front and tte_back.
module three_timer_sound_envelope_top
#(
    parameter int CLOCK_HZ       = 1000000,
    parameter int ENVELOPE_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tick_internal[0], reg_index[3:1], value_high[11:4], value_low[19:12], zeros above
    input  logic [23:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tone1_play[0], tone1_stop[1], tone2_play[2], tone2_stop[3], tone1_hz[22:4],
    // tone2_hz[41:23], volume_set[42], volume_level[49:43], noise_play[50],
    // noise_stop[51], noise_rate[71:52], timer_levels[74:72], zeros above
    output logic [79:0] m_axis_tdata
);

    logic           q_valid;
    logic           q_pop;
    tte_pkg::item_t q_item;

    tte_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .in_user  (s_axis_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    tte_back
    #(
        .CLOCK_HZ       (CLOCK_HZ),
        .ENVELOPE_STEPS (ENVELOPE_STEPS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// File: hdl/tte_front.sv
// Front end: accepts input beats, classifies them and holds them in a two-entry queue.
// Depends on tte_pkg.
module tte_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tte_pkg::IN_DATA_W-1:0] in_data,
    input  logic [tte_pkg::IN_USER_W-1:0] in_user,
    output logic                          q_valid,
    output tte_pkg::item_t                q_item,
    input  logic                          q_pop
);

    tte_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    tte_pkg::item_t item_in;
    logic           push;

    always_comb
    begin
        item_in.is_tick       = (in_user == tte_pkg::OP_TICK);
        item_in.is_timer_wr   = (in_user == tte_pkg::OP_TIMER);
        item_in.is_board_wr   = (in_user == tte_pkg::OP_BOARD);
        item_in.tick_internal = in_data[0];
        item_in.reg_index     = in_data[3:1];
        item_in.value_high    = in_data[11:4];
        item_in.value_low     = in_data[19:12];
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= item_in;
    end

endmodule

// File: hdl/tte_back.sv
// Back end: timers, envelope, tone frequency divider and the output register.
// Depends on tte_pkg.
module tte_back
#(
    parameter int CLOCK_HZ       = 1000000,
    parameter int ENVELOPE_STEPS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  tte_pkg::item_t                 q_item,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tte_pkg::OUT_DATA_W-1:0] out_data
);

    localparam int DIV_W = $clog2(CLOCK_HZ + 1);
    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(CLOCK_HZ);
    localparam logic [tte_pkg::STEP_W-1:0] STEPS = tte_pkg::STEP_W'(ENVELOPE_STEPS);

    logic [15:0] latch_reg [3], latch_next [3];
    logic [15:0] count_reg [3], count_next [3];
    logic [15:0] played_reg [2], played_next [2];
    logic [7:0]  cb_reg [3], cb_next [3];
    logic [2:0]  level_reg, level_next;
    logic        hold_reg, hold_next;
    logic [tte_pkg::STEP_W-1:0] step_reg, step_next;
    logic        rising_reg, rising_next;
    logic        repeat_reg, repeat_next;
    logic        alt_reg, alt_next;
    logic [tte_pkg::HZ_W-1:0] hz_reg [2], hz_next [2];

    tte_pkg::back_state_t state_reg, state_next;
    logic             sel_reg, sel_next;
    logic             stop_pend_reg, stop_pend_next;
    logic [17:0]      divisor_reg, divisor_next;
    logic [17:0]      rem_reg, rem_next;
    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             out_valid_reg, out_valid_next;
    logic [tte_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic        slot_free;
    logic        emit;
    logic [1:0]  play, stop;
    logic        vol_set, n_play, n_stop;
    logic [tte_pkg::RATE_W-1:0] n_rate;
    logic [18:0] trial;
    logic [15:0] v16;
    logic [15:0] dec;

    assign slot_free = !out_valid_reg || out_ready;
    assign trial     = {rem_reg, dvd_reg[DIV_W-1]};
    assign v16       = {q_item.value_high, q_item.value_low};

    always_comb
    begin
        latch_next     = latch_reg;
        count_next     = count_reg;
        played_next    = played_reg;
        cb_next        = cb_reg;
        level_next     = level_reg;
        hold_next      = hold_reg;
        step_next      = step_reg;
        rising_next    = rising_reg;
        repeat_next    = repeat_reg;
        alt_next       = alt_reg;
        hz_next        = hz_reg;
        state_next     = state_reg;
        sel_next       = sel_reg;
        stop_pend_next = stop_pend_reg;
        divisor_next   = divisor_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        q_pop          = 1'b0;
        emit           = 1'b0;
        play           = 2'b00;
        stop           = 2'b00;
        vol_set        = 1'b0;
        n_play         = 1'b0;
        n_stop         = 1'b0;
        n_rate         = '0;
        dec            = '0;

        unique case (state_reg)
            tte_pkg::ST_RUN:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop = 1'b1;
                    emit  = 1'b1;
                    if (q_item.is_tick)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            if (cb_reg[i][1] == q_item.tick_internal && cb_reg[i][7] &&
                                !hold_reg)
                            begin
                                dec = (count_reg[i] != 16'd0) ? count_reg[i] - 16'd1
                                                              : 16'd0;
                                count_next[i] = dec;
                                if (dec == 16'd0 && latch_reg[i] != 16'd0)
                                begin
                                    count_next[i] = latch_reg[i];
                                    if (i < 2)
                                    begin
                                        if (latch_reg[i] != played_reg[i])
                                            play[i] = 1'b1;
                                        played_next[i] = latch_reg[i];
                                    end
                                    level_next[i] = !level_reg[i];
                                    // A rising level of timer 3 moves the envelope on.
                                    if (i == 2 && !level_reg[2])
                                    begin
                                        vol_set = 1'b1;
                                        if (step_reg != '0 && step_reg <= STEPS)
                                            step_next = step_reg + 1'b1;
                                        if (step_next > STEPS)
                                        begin
                                            if (!repeat_reg)
                                            begin
                                                if (!rising_reg)
                                                    step_next = '0;
                                            end
                                            else
                                            begin
                                                step_next = tte_pkg::STEP_W'(1);
                                                if (alt_reg)
                                                    rising_next = !rising_reg;
                                            end
                                        end
                                    end
                                end
                            end
                        end
                    end
                    else if (q_item.is_timer_wr)
                    begin
                        priority if (q_item.reg_index == tte_pkg::REG_LATCH1 ||
                                     q_item.reg_index == tte_pkg::REG_LATCH2)
                        begin
                            // Tone latches wait for the frequency divider.
                            emit = 1'b0;
                            sel_next = q_item.reg_index[2];
                            latch_next[q_item.reg_index[2]] = v16;
                            count_next[q_item.reg_index[2]] = v16;
                            stop_pend_next = !q_item.reg_index[2] && (v16 == 16'd0);
                            divisor_next   = {17'(v16) + 17'd1, 1'b0};
                            rem_next       = '0;
                            dvd_next       = DIVIDEND;
                            quot_next      = '0;
                            cnt_next       = CNT_W'(DIV_W - 1);
                            state_next     = tte_pkg::ST_DIV;
                        end
                        else if (q_item.reg_index == tte_pkg::REG_LATCH3)
                        begin
                            latch_next[2] = v16;
                            count_next[2] = v16;
                        end
                        else if (q_item.reg_index == tte_pkg::REG_CR2)
                        begin
                            cb_next[1] = q_item.value_low;
                            if (q_item.value_low[7])
                            begin
                                if (latch_reg[1] != 16'd0 && !hold_reg)
                                    play[1] = 1'b1;
                            end
                            else
                            begin
                                stop[1]   = 1'b1;
                                step_next = '0;
                            end
                            level_next[1] = 1'b0;
                        end
                        else if (q_item.reg_index == tte_pkg::REG_CR13)
                        begin
                            if (cb_reg[1][0])
                            begin
                                cb_next[0] = q_item.value_low;
                                hold_next  = q_item.value_low[0];
                                if (q_item.value_low[0])
                                begin
                                    count_next = latch_reg;
                                    level_next = 3'b000;
                                    stop       = 2'b11;
                                end
                                if (q_item.value_low[7])
                                begin
                                    if (latch_reg[0] != 16'd0 && !q_item.value_low[0])
                                        play[0] = 1'b1;
                                end
                                else
                                    stop[0] = 1'b1;
                            end
                            else
                                cb_next[2] = q_item.value_low;
                        end
                        else
                        begin
                            // Unused register addresses change nothing.
                        end
                    end
                    else if (q_item.is_board_wr)
                    begin
                        repeat_next = q_item.value_low[2];
                        alt_next    = q_item.value_low[1];
                        rising_next = q_item.value_low[0];
                        n_rate      = tte_pkg::noise_rate_of(q_item.value_low[7:4]);
                        n_play      = q_item.value_low[3];
                        n_stop      = !q_item.value_low[3];
                        step_next   = tte_pkg::STEP_W'(1);
                        vol_set     = 1'b1;
                    end
                end
            end
            tte_pkg::ST_DIV:
            begin
                // One quotient bit per cycle, restoring division.
                if (trial >= {1'b0, divisor_reg})
                begin
                    rem_next  = 18'(trial - {1'b0, divisor_reg});
                    quot_next = {quot_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[17:0];
                    quot_next = {quot_reg[DIV_W-2:0], 1'b0};
                end
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = tte_pkg::ST_DONE;
            end
            tte_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    emit    = 1'b1;
                    stop[0] = stop_pend_reg;
                    hz_next[sel_reg] = (quot_reg > DIV_W'(tte_pkg::HZ_MAX)) ? tte_pkg::HZ_MAX
                                       : tte_pkg::HZ_W'(quot_reg);
                    state_next = tte_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = tte_pkg::ST_RUN;
            end
        endcase

        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {5'd0, level_next, n_rate, n_stop, n_play,
                              tte_pkg::vol_of(step_next, rising_next, STEPS), vol_set,
                              hz_next[1], hz_next[0], stop[1], play[1], stop[0], play[0]};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                latch_reg[i] <= '0;
                count_reg[i] <= '0;
                cb_reg[i]    <= '0;
            end
            for (int i = 0; i < 2; i++)
            begin
                played_reg[i] <= '0;
                hz_reg[i]     <= '0;
            end
            level_reg     <= '0;
            hold_reg      <= 1'b0;
            step_reg      <= '0;
            rising_reg    <= 1'b0;
            repeat_reg    <= 1'b0;
            alt_reg       <= 1'b0;
            state_reg     <= tte_pkg::ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            latch_reg     <= latch_next;
            count_reg     <= count_next;
            cb_reg        <= cb_next;
            played_reg    <= played_next;
            hz_reg        <= hz_next;
            level_reg     <= level_next;
            hold_reg      <= hold_next;
            step_reg      <= step_next;
            rising_reg    <= rising_next;
            repeat_reg    <= repeat_next;
            alt_reg       <= alt_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg       <= sel_next;
        stop_pend_reg <= stop_pend_next;
        divisor_reg   <= divisor_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        quot_reg      <= quot_next;
        cnt_reg       <= cnt_next;
        out_data_reg  <= out_data_next;
    end

endmodule

// File: hdl/tte_checker.sv
// Port-level checks for the three timer sound envelope block, bound to the top level.
// Depends on three_timer_sound_envelope_top.
module tte_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);

    // A result beat that is not taken stays as it is.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[50] && m_axis_tdata[51]))
        else $error("noise play and stop together");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("tone one play and stop together");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[49:43] <= 7'd100 && m_axis_tdata[79:75] == 5'd0)
        else $error("volume out of range or padding not zero");

endmodule

bind three_timer_sound_envelope_top tte_checker u_tte_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
